[sv/ptc_pkg.sv]
// Package for the perceptron train/classify block: widths, codes, FSM states,
// and the command/status structs between controller and datapath.
// No dependencies.
package ptc_pkg;

  localparam int VALUE_W          = 16;  // Q4.12 weights and features
  localparam int FRAC_BITS        = 12;
  localparam int ACC_W            = 40;  // Q16.24 accumulator
  localparam int SCORE_W          = 32;
  localparam int LR_W             = 16;
  localparam int NFEAT_W          = 4;
  localparam int WIDX_W           = 4;
  localparam int ACT_W            = 2;
  localparam int LABEL_W          = 2;
  localparam int CLASS_W          = 2;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;
  localparam int MUL_A_W          = VALUE_W + 1;
  localparam int PROD_W           = VALUE_W + LR_W + 1;
  localparam int TERM_W           = PROD_W + 2;
  localparam int MAX_FEATURES_DEF = 8;

  localparam logic [LR_W-1:0]    LR_RESET    = LR_W'(66);
  localparam logic [NFEAT_W-1:0] NFEAT_RESET = NFEAT_W'(8);

  localparam logic signed [CLASS_W-1:0] CLASS_POS = 2'sb01;
  localparam logic signed [CLASS_W-1:0] CLASS_NEG = 2'sb11;

  typedef enum logic [ACT_W-1:0] {
    ACT_PREDICT = 2'd0,
    ACT_TRAIN   = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE   = 1'b0,
    REG_FEATURES_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMUL,
    S_FACC,
    S_SCORE,
    S_TCHK,
    S_TRD,
    S_TMUL,
    S_TWR,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_w;    // write one weight from the request
    logic capture;   // latch label of a feature request
    logic take;      // store feature, read its weight
    logic mul_feat;  // weight * feature
    logic acc_feat;  // add product into accumulator
    logic rd_bias;   // read bias weight
    logic score;     // form score, clear update index
    logic trn_rd;    // read weight and feature for update
    logic trn_mul;   // alpha * feature
    logic trn_wr;    // write updated weight
    logic emit;      // present result, clear sample state
  } dp_cmd_t;

  typedef struct packed {
    logic pos_lt_active;
    logic err_zero;
    logic trn_last;
  } dp_status_t;

endpackage

[sv/ptc_ctrl.sv]
// Controller FSM: sequences feature MACs, scoring, the weight update walk
// and result output. Depends on ptc_pkg.
module ptc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ptc_pkg::ACT_W-1:0]  in_action,
  input  logic                       in_last_feature,
  input  ptc_pkg::dp_status_t        status,
  output ptc_pkg::dp_cmd_t           cmd,
  output logic                       busy
);
  import ptc_pkg::*;

  state_t  state_r, state_nxt;
  logic    last_r, last_nxt;
  logic    train_r, train_nxt;
  action_t act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      train_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      train_r <= train_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    last_nxt  = last_r;
    train_nxt = train_r;
    act       = action_t'(in_action);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (act)
            ACT_LOAD: cmd.load_w = 1'b1;
            ACT_PREDICT, ACT_TRAIN: begin
              cmd.capture = 1'b1;
              last_nxt    = in_last_feature;
              train_nxt   = (act == ACT_TRAIN);
              if (status.pos_lt_active) begin
                cmd.take  = 1'b1;
                state_nxt = S_FMUL;
              end else if (in_last_feature) begin
                // excess feature closing the sample
                cmd.rd_bias = 1'b1;
                state_nxt   = S_SCORE;
              end
            end
            default: ;
          endcase
        end
      end
      S_FMUL: begin
        cmd.mul_feat = 1'b1;
        state_nxt    = S_FACC;
      end
      S_FACC: begin
        cmd.acc_feat = 1'b1;
        if (last_r) begin
          cmd.rd_bias = 1'b1;
          state_nxt   = S_SCORE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCORE: begin
        cmd.score = 1'b1;
        state_nxt = train_r ? S_TCHK : S_EMIT;
      end
      S_TCHK: begin
        state_nxt = status.err_zero ? S_EMIT : S_TRD;
      end
      S_TRD: begin
        cmd.trn_rd = 1'b1;
        state_nxt  = S_TMUL;
      end
      S_TMUL: begin
        cmd.trn_mul = 1'b1;
        state_nxt   = S_TWR;
      end
      S_TWR: begin
        cmd.trn_wr = 1'b1;
        state_nxt  = status.trn_last ? S_EMIT : S_TRD;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_twr_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TWR && !status.trn_last) |=> (state_r == S_TRD))
    else $error("update walk did not continue");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE && !busy))
    else $error("not idle after result");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_w, cmd.take, cmd.mul_feat, cmd.acc_feat, cmd.score,
              cmd.trn_rd, cmd.trn_mul, cmd.trn_wr, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule

[sv/ptc_dp.sv]
// Datapath: config registers, weight store and feature buffer, shared
// multiplier, accumulator, weight update and result registers. Depends on ptc_pkg.
module ptc_dp #(
  parameter int MAX_FEATURES = ptc_pkg::MAX_FEATURES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [ptc_pkg::WIDX_W-1:0]          in_weight_index,
  input  logic signed [ptc_pkg::VALUE_W-1:0]  in_sample_value,
  input  logic signed [ptc_pkg::LABEL_W-1:0]  in_target_label,
  input  ptc_pkg::dp_cmd_t                    cmd,
  output ptc_pkg::dp_status_t                 status,
  output logic                                out_strobe,
  output logic signed [ptc_pkg::SCORE_W-1:0]  out_raw_score,
  output logic signed [ptc_pkg::CLASS_W-1:0]  out_predicted_class,
  output logic                                out_weights_changed
);
  import ptc_pkg::*;

  localparam int WI  = $clog2(MAX_FEATURES + 1);
  localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW0 = (WI > NFEAT_W) ? WI : NFEAT_W;
  localparam int CW  = (CW0 > WIDX_W) ? CW0 : WIDX_W;
  localparam int NW  = TERM_W - LR_W + 1;
  localparam logic [TERM_W-1:0]         RND    = TERM_W'(1) << (LR_W - 1);
  localparam logic signed [VALUE_W-1:0] ONE_Q  = VALUE_W'(1) << FRAC_BITS;
  localparam logic signed [VALUE_W-1:0] W_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] W_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1])
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      r = v[ACC_W-1:0];
    return r;
  endfunction

  // config
  logic [LR_W-1:0]    lr_r;
  logic [NFEAT_W-1:0] nfeat_r;

  // storage
  logic signed [VALUE_W-1:0] wmem [0:MAX_FEATURES];
  logic [MAX_FEATURES:0]     wvalid_r;
  logic signed [VALUE_W-1:0] fbuf [0:MAX_FEATURES-1];
  logic signed [VALUE_W-1:0] wrd_r, frd_r, val_r;

  // sample state
  logic [WI-1:0]             pos_r, k_r, km1;
  logic signed [ACC_W-1:0]   acc_r, score_r;
  logic signed [PROD_W-1:0]  prod_r, prod_c;
  logic                      label_neg_r, changed_r, bias_sel_r;

  // output registers
  logic                      out_strobe_r, out_changed_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic signed [CLASS_W-1:0] out_class_r;

  // comb
  logic [CW-1:0]             idx_ext;
  logic                      w_we, w_re;
  logic [WI-1:0]             w_waddr, w_raddr;
  logic signed [VALUE_W-1:0] w_wdata, w_new, mul_b;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [ACC_W:0]     acc_sum, score_sum;
  logic signed [TERM_W-1:0]  p2, term, biased;
  logic signed [NW-1:0]      w_sum;
  logic signed [SCORE_W-1:0] score_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= LR_RESET;
      nfeat_r <= NFEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEARNING_RATE:   lr_r    <= cfg_wdata[LR_W-1:0];
        REG_FEATURES_IN_USE: nfeat_r <= cfg_wdata[NFEAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign idx_ext = CW'(in_weight_index);
  assign km1     = k_r - WI'(1);

  // weight store port muxing
  always_comb begin
    w_we    = 1'b0;
    w_waddr = k_r;
    w_wdata = w_new;
    if (cmd.load_w) begin
      w_we    = (idx_ext <= CW'(MAX_FEATURES));
      w_waddr = idx_ext[WI-1:0];
      w_wdata = in_sample_value;
    end else if (cmd.trn_wr) begin
      w_we = 1'b1;
    end
    w_re = cmd.take | cmd.rd_bias | cmd.trn_rd;
    priority if (cmd.take)    w_raddr = WI'(pos_r + WI'(1));
    else if (cmd.rd_bias)     w_raddr = '0;
    else                      w_raddr = k_r;
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    if (w_re) wrd_r <= wvalid_r[w_raddr] ? wmem[w_raddr] : '0;
    if (cmd.take) fbuf[pos_r[FW-1:0]] <= in_sample_value;
    if (cmd.trn_rd) frd_r <= fbuf[km1[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wvalid_r <= '0;
    else if (w_we) wvalid_r[w_waddr] <= 1'b1;
  end

  // shared multiplier: weight*feature or alpha*feature
  always_comb begin
    if (cmd.trn_mul) begin
      mul_a = {1'b0, lr_r};
      mul_b = bias_sel_r ? ONE_Q : frd_r;
    end else begin
      mul_a = {wrd_r[VALUE_W-1], wrd_r};
      mul_b = val_r;
    end
    prod_c = mul_a * mul_b;
  end

  assign acc_sum   = {acc_r[ACC_W-1], acc_r}
                   + {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign score_sum = {acc_r[ACC_W-1], acc_r}
                   + {{(ACC_W+1-VALUE_W-FRAC_BITS){wrd_r[VALUE_W-1]}}, wrd_r,
                      {FRAC_BITS{1'b0}}};

  // err is +2 or -2; round half up then drop the alpha fraction
  assign p2     = {prod_r[PROD_W-1], prod_r, 1'b0};
  assign term   = label_neg_r ? -p2 : p2;
  assign biased = term + RND;
  assign w_sum  = {{(NW-VALUE_W){wrd_r[VALUE_W-1]}}, wrd_r}
                + {biased[TERM_W-1], biased[TERM_W-1:LR_W]};

  always_comb begin
    if (w_sum[NW-1:VALUE_W-1] == '0 || w_sum[NW-1:VALUE_W-1] == '1)
      w_new = w_sum[VALUE_W-1:0];
    else
      w_new = w_sum[NW-1] ? W_MIN : W_MAX;
    if (score_r[ACC_W-1:SCORE_W-1] == '0 || score_r[ACC_W-1:SCORE_W-1] == '1)
      score_sat = score_r[SCORE_W-1:0];
    else
      score_sat = score_r[ACC_W-1] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                   : {1'b0, {(SCORE_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) label_neg_r <= in_target_label[LABEL_W-1];
    if (cmd.take) val_r <= in_sample_value;
    if (cmd.mul_feat || cmd.trn_mul) prod_r <= prod_c;
    if (cmd.score) score_r <= sat_acc(score_sum);
    if (cmd.trn_rd) bias_sel_r <= (k_r == '0);
    if (cmd.emit) begin
      out_score_r   <= score_sat;
      out_class_r   <= score_r[ACC_W-1] ? CLASS_NEG : CLASS_POS;
      out_changed_r <= changed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      pos_r        <= '0;
      k_r          <= '0;
      changed_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.acc_feat) begin
        acc_r <= sat_acc(acc_sum);
        pos_r <= pos_r + WI'(1);
      end
      if (cmd.score) begin
        k_r       <= '0;
        changed_r <= 1'b0;
      end
      if (cmd.trn_wr) begin
        k_r       <= k_r + WI'(1);
        changed_r <= changed_r | (w_new != wrd_r);
      end
      if (cmd.emit) begin
        acc_r <= '0;
        pos_r <= '0;
      end
    end
  end

  assign status.pos_lt_active = (CW'(pos_r) < CW'(nfeat_r))
                             && (CW'(pos_r) < CW'(MAX_FEATURES));
  assign status.err_zero      = (label_neg_r == score_r[ACC_W-1]);
  assign status.trn_last      = (k_r == pos_r);

  assign out_strobe          = out_strobe_r;
  assign out_raw_score       = out_score_r;
  assign out_predicted_class = out_class_r;
  assign out_weights_changed = out_changed_r;

  a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (pos_r == '0 && acc_r == '0))
    else $error("sample state not cleared with result");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_class_r == CLASS_POS || out_class_r == CLASS_NEG))
    else $error("bad class code");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trn_wr |-> (k_r <= pos_r))
    else $error("update walk past sample length");

endmodule

[sv/perceptron_train_and_classify_top.sv]
// Top level of the perceptron classifier with Rosenblatt training.
// Depends on ptc_pkg, ptc_ctrl, ptc_dp.
//
//   channel   handshake          payload
//   in_       start / busy       action, weight_index, sample_value, target_label,
//                                last_feature
//   out_      out_strobe         raw_score, predicted_class, weights_changed
//   cfg_      cfg_we             cfg_index, cfg_wdata
//
// A weight load writes one weight from the request; a counted feature takes a weight
// read, multiply and accumulate, an excess feature none of these. The last feature
// adds score and result steps for predict; train adds an error check and, with a
// misclassified sample, one weight read, multiply and write-back per weight for
// n+1 weights, n = features counted, through the shared multiplier. out_strobe
// rises in the cycle after the result step.
// Synchronous reset clears weights, sample state and config to defaults.
// out_strobe marks each result for exactly one cycle; the payload holds until the next.
module perceptron_train_and_classify_top #(
  parameter int MAX_FEATURES = ptc_pkg::MAX_FEATURES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ptc_pkg::ACT_W-1:0]           in_action,
  input  logic [ptc_pkg::WIDX_W-1:0]          in_weight_index,
  input  logic signed [ptc_pkg::VALUE_W-1:0]  in_sample_value,
  input  logic signed [ptc_pkg::LABEL_W-1:0]  in_target_label,
  input  logic                                in_last_feature,
  output logic                                out_strobe,
  output logic signed [ptc_pkg::SCORE_W-1:0]  out_raw_score,
  output logic signed [ptc_pkg::CLASS_W-1:0]  out_predicted_class,
  output logic                                out_weights_changed,
  input  logic                                cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ptc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ptc_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_action       (in_action),
    .in_last_feature (in_last_feature),
    .status          (status),
    .cmd             (cmd),
    .busy            (busy)
  );

  ptc_dp #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_weight_index     (in_weight_index),
    .in_sample_value     (in_sample_value),
    .in_target_label     (in_target_label),
    .cmd                 (cmd),
    .status              (status),
    .out_strobe          (out_strobe),
    .out_raw_score       (out_raw_score),
    .out_predicted_class (out_predicted_class),
    .out_weights_changed (out_weights_changed)
  );

endmodule
